// File: hdl/nrbm_pkg.sv
package nrbm_pkg;

  // defaults for the top-level parameters
  localparam int MAX_WIDTH_DEF = 2048;
  localparam int TAPS_DEF      = 9;

  // fixed frame limits and field widths
  localparam int HEIGHT_MAX  = 2048;
  localparam int ROW_BITS    = 12;
  localparam int CFG_BITS    = 12;
  localparam int INDEX_BITS  = 2;
  localparam int SUM_BITS    = 32;
  localparam int SCORE_BITS  = 17;

  localparam int WIDTH_RESET  = 640;
  localparam int HEIGHT_RESET = 480;

  // register indexes
  localparam logic [INDEX_BITS-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [INDEX_BITS-1:0] REG_FRAME_HEIGHT = 2'd1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HSUM,
    ST_HDIV,
    ST_HACC,
    ST_VRD,
    ST_VDIV,
    ST_VACC,
    ST_ADV,
    ST_RATIO_H,
    ST_RATIO_V,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic                start;
    logic [SUM_BITS-1:0] sf;
    logic [SUM_BITS-1:0] sv;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [SCORE_BITS-1:0] quotient;
  } div_rsp_t;

endpackage

// File: hdl/nrbm_pix_if.sv
interface nrbm_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

// File: hdl/nrbm_res_if.sv
interface nrbm_res_if;
  logic        valid;
  logic        ready;
  logic [16:0] blur_score;
  logic        flat_frame;

  modport source (output valid, output blur_score, output flat_frame, input ready);
  modport sink   (input valid, input blur_score, input flat_frame, output ready);
endinterface

// File: hdl/nrbm_ratio.sv
module nrbm_ratio (
  input  logic               clk,
  input  logic               rst,
  input  nrbm_pkg::div_req_t req,
  output nrbm_pkg::div_rsp_t rsp
);
  import nrbm_pkg::*;

  localparam int QB = SCORE_BITS;
  localparam int CW = $clog2(QB + 1);

  logic                  busy;
  logic                  done;
  logic [SUM_BITS:0]     rem;
  logic [SUM_BITS-1:0]   den;
  logic [QB-1:0]         q;
  logic [CW-1:0]         cnt;
  logic [SUM_BITS:0]     trial;
  logic                  ge;

  // first quotient bit weighs 1.0, so no shift on that step
  always_comb begin
    trial = (cnt == CW'(QB)) ? rem : {rem[SUM_BITS-1:0], 1'b0};
    ge    = trial >= {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (!busy && req.start) begin
        if (req.sf == '0) begin
          q    <= '0;
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
          den  <= req.sf;
          rem  <= (req.sv > req.sf) ? '0 : {1'b0, req.sf - req.sv};
          cnt  <= CW'(QB);
        end
      end else if (busy) begin
        rem <= ge ? trial - {1'b0, den} : trial;
        q   <= {q[QB-2:0], ge};
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = q;

endmodule

// File: hdl/no_reference_blur_metric.sv
// no-reference blur metric over one grayscale frame
//
// pix channel: one pixel word per handshake, raster order, frame_width pixels
// a row and frame_height rows a frame. res channel: one word per frame, the
// blur score in unsigned Q1.16 (65536 is 1.0) and a flat-frame flag.
// cfg port: cfg_write with cfg_index 0 (frame_width) or 1 (frame_height);
// any such write restarts the frame in progress. Write only while idle.
//
// pixel path: a pixel runs only the horizontal states in the first TAPS/2
// rows and also a column sweep after, which reads one stored row per cycle
// from the single-port line memory; the last pixel of a row repeats the
// horizontal states once per trailing horizontal tap (TAPS/2 of them).
// no pixel is taken until the last is through. after the last pixel the
// final TAPS/2 blurred rows are swept column by column, then two 17-step
// divides give the score, which is written to the output register.
// reset: no pending result, counters and sums cleared, registers 640 x 480.
// a stalled receiver holds the score in the output register; the block keeps
// taking pixels and waits only if the next frame's score is ready first.
module no_reference_blur_metric #(
  parameter int MAX_WIDTH = nrbm_pkg::MAX_WIDTH_DEF,
  parameter int TAPS      = nrbm_pkg::TAPS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  nrbm_pix_if.sink                            pix,
  nrbm_res_if.source                          res,
  input  logic                                cfg_write,
  input  logic [nrbm_pkg::INDEX_BITS-1:0]     cfg_index,
  input  logic [nrbm_pkg::CFG_BITS-1:0]       cfg_data
);
  import nrbm_pkg::*;

  localparam int SR        = TAPS - 1;            // rows held in the line memory
  localparam int HALF      = TAPS / 2;
  localparam int LAG       = TAPS - 1 - HALF;
  localparam int XW        = $clog2(MAX_WIDTH + 1);
  localparam int AXW       = $clog2(MAX_WIDTH);
  localparam int YW        = ROW_BITS;
  localparam int SLW       = $clog2(SR);
  localparam int RAW       = $clog2(SR * MAX_WIDTH);
  localparam int SUMW      = $clog2(TAPS * 255 + 1);
  localparam int JW        = $clog2(TAPS + 1);
  localparam int HCW       = $clog2(LAG + 1);
  localparam int DIV_SHIFT = 24;
  localparam int DIV_MULT  = ((1 << DIV_SHIFT) + TAPS - 1) / TAPS;
  localparam int PW        = SUMW + DIV_SHIFT;

  // tap sum / TAPS by reciprocal, exact for sums below 2^12
  function automatic logic [7:0] div_taps(input logic [SUMW-1:0] s);
    logic [PW-1:0] prod;
    prod = PW'(s) * PW'(DIV_MULT);
    return prod[DIV_SHIFT +: 8];
  endfunction

  function automatic logic [7:0] absd(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  state_t state, state_next;

  // configuration
  logic [CFG_BITS-1:0] cfg_w, cfg_h;
  logic [XW-1:0]       w_eff;
  logic [YW-1:0]       h_eff;

  // frame position
  logic [XW-1:0]  x;
  logic [YW-1:0]  y;
  logic [SLW-1:0] ys;

  // horizontal path
  logic [7:0]      win [TAPS];
  logic [7:0]      pix_r;
  logic [HCW-1:0]  hcnt;
  logic [SUMW-1:0] win_sum, hsum;
  logic [7:0]      hf, hfp, hb, prev_hblur;
  logic [7:0]      hdf, hdb;
  logic            hx_ok, hx_pos, flush_more, vert_on;

  // vertical path
  logic [XW-1:0]   px;
  logic [YW-1:0]   pr;
  logic [YW-1:0]   yref;
  logic [SLW-1:0]  yslot;
  logic [JW-1:0]   nrd, jcnt, pend_j;
  logic            pend, flushing;
  logic [SUMW-1:0] vsum;
  logic [7:0]      vf, vfp, vb;
  logic [7:0]      vdf, vdb;
  logic            flush_last, frame_end;
  logic [YW-1:0]   rstart;

  // sums and result
  logic [SUM_BITS-1:0]   sf_h, sv_h, sf_v, sv_v;
  logic [SCORE_BITS-1:0] sh, sv_q;
  logic                  div_issued;
  div_req_t              div_req;
  div_rsp_t              div_rsp;
  logic                  out_valid, out_load;
  logic [SCORE_BITS-1:0] score_r;
  logic                  flat_r;

  // memories
  logic [7:0]     row_mem [SR * MAX_WIDTH];
  logic [7:0]     blur_mem [MAX_WIDTH];
  logic [7:0]     row_rdata, blur_rdata;
  logic [RAW-1:0] row_raddr, row_waddr;
  logic           row_rd, row_wr, blur_rd, blur_wr;

  // register values out of range fold to the nearest legal size
  always_comb begin
    if (cfg_w == '0)                w_eff = XW'(1);
    else if (int'(cfg_w) > MAX_WIDTH) w_eff = XW'(MAX_WIDTH);
    else                            w_eff = XW'(cfg_w);
    if (cfg_h == '0)                h_eff = YW'(1);
    else if (int'(cfg_h) > HEIGHT_MAX) h_eff = YW'(HEIGHT_MAX);
    else                            h_eff = YW'(cfg_h);
  end

  always_comb begin
    win_sum = '0;
    for (int i = 0; i < TAPS; i++) win_sum = win_sum + SUMW'(win[i]);
  end

  // horizontal point at column x - LAG + hcnt, if on the frame
  always_comb begin
    hx_ok      = (int'(x) + int'(hcnt)) >= LAG;
    hx_pos     = (int'(x) + int'(hcnt)) > LAG;
    hdf        = hx_pos ? absd(hf, hfp) : hf;
    hdb        = hx_pos ? absd(hb, prev_hblur) : hb;
    flush_more = (x == w_eff - XW'(1)) && (int'(hcnt) < LAG);
    vert_on    = int'(y) >= LAG;
  end

  // vertical point: first row of a frame uses the values themselves
  always_comb begin
    vdf        = (pr != '0) ? absd(vf, vfp) : vf;
    vdb        = (pr != '0) ? absd(vb, blur_rdata) : vb;
    flush_last = (px == w_eff - XW'(1)) && (pr == h_eff - YW'(1));
    frame_end  = (x == w_eff - XW'(1)) && (y == h_eff - YW'(1));
    rstart     = (int'(h_eff) > LAG) ? h_eff - YW'(LAG) : '0;
  end

  // line memory slot of tap row pr - HALF + jcnt, clamped to the frame
  always_comb begin
    int k, kc, d, s;
    k  = int'(pr) - HALF + int'(jcnt);
    kc = (k < 0) ? 0 : ((k > int'(h_eff) - 1) ? int'(h_eff) - 1 : k);
    d  = int'(yref) - kc;
    s  = int'(yslot) + SR - d;
    if (s >= SR) s = s - SR;
    row_raddr = RAW'(s * MAX_WIDTH + int'(px[AXW-1:0]));
    row_waddr = RAW'(int'(ys) * MAX_WIDTH + int'(x[AXW-1:0]));
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:    if (pix.valid) state_next = ST_HSUM;
      ST_HSUM:    state_next = ST_HDIV;
      ST_HDIV:    state_next = ST_HACC;
      ST_HACC: begin
        if (flush_more)   state_next = ST_HSUM;
        else if (vert_on) state_next = ST_VRD;
        else              state_next = ST_ADV;
      end
      ST_VRD:     if (jcnt == nrd) state_next = ST_VDIV;
      ST_VDIV:    state_next = ST_VACC;
      ST_VACC: begin
        if (!flushing)       state_next = ST_ADV;
        else if (flush_last) state_next = ST_RATIO_H;
        else                 state_next = ST_VRD;
      end
      ST_ADV:     state_next = frame_end ? ST_VRD : ST_IDLE;
      ST_RATIO_H: if (div_rsp.done) state_next = ST_RATIO_V;
      ST_RATIO_V: if (div_rsp.done) state_next = ST_RESULT;
      ST_RESULT:  if (out_load) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    pix.ready     = (state == ST_IDLE);
    row_rd        = (state == ST_VRD) && (jcnt < nrd);
    row_wr        = (state == ST_ADV);
    blur_rd       = (state == ST_VDIV);
    blur_wr       = (state == ST_VACC);
    out_load      = (state == ST_RESULT) && (!out_valid || res.ready);
    div_req.start = ((state == ST_RATIO_H) || (state == ST_RATIO_V)) && !div_issued;
    div_req.sf    = (state == ST_RATIO_V) ? sf_v : sf_h;
    div_req.sv    = (state == ST_RATIO_V) ? sv_v : sv_h;
  end

  nrbm_ratio u_ratio (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (row_rd) row_rdata <= row_mem[row_raddr];
    if (row_wr) row_mem[row_waddr] <= pix_r;
  end

  always_ff @(posedge clk) begin
    if (blur_rd) blur_rdata <= blur_mem[px[AXW-1:0]];
    if (blur_wr) blur_mem[px[AXW-1:0]] <= vb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cfg_w      <= CFG_BITS'(WIDTH_RESET);
      cfg_h      <= CFG_BITS'(HEIGHT_RESET);
      x          <= '0;
      y          <= '0;
      ys         <= '0;
      sf_h       <= '0;
      sv_h       <= '0;
      sf_v       <= '0;
      sv_v       <= '0;
      prev_hblur <= '0;
      pend       <= 1'b0;
      flushing   <= 1'b0;
      div_issued <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          if (pix.valid) begin
            pix_r <= pix.pixel;
            hcnt  <= '0;
            // start of a row: edge pixel fills every tap
            for (int i = 0; i < TAPS - 1; i++) win[i] <= (x == '0) ? pix.pixel : win[i+1];
            win[TAPS-1] <= pix.pixel;
          end
        end
        ST_HSUM: begin
          hsum <= win_sum;
          hf   <= win[HALF];
          hfp  <= win[HALF-1];
        end
        ST_HDIV: hb <= div_taps(hsum);
        ST_HACC: begin
          if (hx_ok) begin
            sf_h <= sf_h + SUM_BITS'(hdf);
            if (hdf > hdb) sv_h <= sv_h + SUM_BITS'(hdf - hdb);
            prev_hblur <= hb;
          end
          if (flush_more) begin
            // end of row: repeat the edge pixel into the trailing taps
            for (int i = 0; i < TAPS - 1; i++) win[i] <= win[i+1];
            win[TAPS-1] <= pix_r;
            hcnt <= hcnt + HCW'(1);
          end else if (vert_on) begin
            px    <= x;
            pr    <= y - YW'(LAG);
            yref  <= y;
            yslot <= ys;
            nrd   <= JW'(TAPS - 1);
            vsum  <= SUMW'(pix_r);
            jcnt  <= '0;
            pend  <= 1'b0;
          end
        end
        ST_VRD: begin
          if (pend) begin
            vsum <= vsum + SUMW'(row_rdata);
            if (int'(pend_j) == HALF)     vf  <= row_rdata;
            if (int'(pend_j) == HALF - 1) vfp <= row_rdata;
          end
          if (jcnt < nrd) begin
            pend_j <= jcnt;
            jcnt   <= jcnt + JW'(1);
            pend   <= 1'b1;
          end else begin
            pend <= 1'b0;
          end
        end
        ST_VDIV: vb <= div_taps(vsum);
        ST_VACC: begin
          sf_v <= sf_v + SUM_BITS'(vdf);
          if (vdf > vdb) sv_v <= sv_v + SUM_BITS'(vdf - vdb);
          if (flushing && !flush_last) begin
            if (px == w_eff - XW'(1)) begin
              px <= '0;
              pr <= pr + YW'(1);
            end else begin
              px <= px + XW'(1);
            end
            vsum <= '0;
            jcnt <= '0;
            pend <= 1'b0;
          end
        end
        ST_ADV: begin
          if (x == w_eff - XW'(1)) begin
            x <= '0;
            if (frame_end) begin
              // sweep the last rows of the vertical blur
              y        <= '0;
              ys       <= '0;
              yref     <= h_eff;
              yslot    <= (int'(ys) == SR - 1) ? '0 : ys + SLW'(1);
              pr       <= rstart;
              px       <= '0;
              nrd      <= JW'(TAPS);
              vsum     <= '0;
              jcnt     <= '0;
              pend     <= 1'b0;
              flushing <= 1'b1;
            end else begin
              y  <= y + YW'(1);
              ys <= (int'(ys) == SR - 1) ? '0 : ys + SLW'(1);
            end
          end else begin
            x <= x + XW'(1);
          end
        end
        ST_RATIO_H: begin
          if (div_rsp.done) begin
            sh         <= div_rsp.quotient;
            div_issued <= 1'b0;
          end else if (!div_issued) begin
            div_issued <= 1'b1;
          end
        end
        ST_RATIO_V: begin
          if (div_rsp.done) begin
            sv_q       <= div_rsp.quotient;
            div_issued <= 1'b0;
          end else if (!div_issued) begin
            div_issued <= 1'b1;
          end
        end
        ST_RESULT: begin
          if (out_load) begin
            score_r    <= (sh > sv_q) ? sh : sv_q;
            flat_r     <= (sf_h == '0) || (sf_v == '0);
            sf_h       <= '0;
            sv_h       <= '0;
            sf_v       <= '0;
            sv_v       <= '0;
            prev_hblur <= '0;
            flushing   <= 1'b0;
          end
        end
        default: ;
      endcase

      // output register
      if (out_load)       out_valid <= 1'b1;
      else if (res.ready) out_valid <= 1'b0;

      // a register write restarts the frame
      if (cfg_write && (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT)) begin
        if (cfg_index == REG_FRAME_WIDTH) cfg_w <= cfg_data;
        else                              cfg_h <= cfg_data;
        x          <= '0;
        y          <= '0;
        ys         <= '0;
        sf_h       <= '0;
        sv_h       <= '0;
        sf_v       <= '0;
        sv_v       <= '0;
        prev_hblur <= '0;
      end
    end
  end

  assign res.valid      = out_valid;
  assign res.blur_score = score_r;
  assign res.flat_frame = flat_r;

endmodule
